// ===== design/sctk_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package sctk_pkg;

    // Layout table depth and its index width
    localparam int LAYOUT_ENTRIES = 58;
    localparam int LAYOUT_AW      = $clog2(LAYOUT_ENTRIES);

    // Scancode set 1 bytes
    localparam logic [7:0] SC_PREFIX      = 8'hE0;
    localparam logic [7:0] SC_LSHIFT      = 8'h2A;
    localparam logic [7:0] SC_RSHIFT      = 8'h36;
    localparam logic [7:0] SC_LSHIFT_UP   = 8'hAA;
    localparam logic [7:0] SC_RSHIFT_UP   = 8'hB6;
    localparam logic [7:0] SC_CTRL        = 8'h1D;
    localparam logic [7:0] SC_CTRL_UP     = 8'h9D;
    localparam logic [7:0] SC_ARROW_UP    = 8'h48;
    localparam logic [7:0] SC_ARROW_DOWN  = 8'h50;
    localparam logic [7:0] SC_ARROW_LEFT  = 8'h4B;
    localparam logic [7:0] SC_ARROW_RIGHT = 8'h4D;
    localparam logic [7:0] SC_ESC         = 8'h01;
    localparam logic [7:0] SC_BACKSPACE   = 8'h0E;
    localparam logic [7:0] SC_KEY_S       = 8'h1F;
    localparam logic [7:0] SC_KEY_C       = 8'h2E;
    localparam logic [7:0] SC_KEY_V       = 8'h2F;
    localparam logic [7:0] SC_KEY_Y       = 8'h2C;
    localparam logic [7:0] SC_KEY_Z       = 8'h15;

    // Fixed characters
    localparam logic [7:0] CHAR_ESC       = 8'h1B;
    localparam logic [7:0] CHAR_BACKSPACE = 8'h08;

    // Result kinds
    localparam logic KIND_CHAR    = 1'b0;
    localparam logic KIND_SPECIAL = 1'b1;

    // Special key indexes; shift adds SPECIAL_SHIFT_BIT to an arrow
    localparam logic [7:0] SPECIAL_UP     = 8'd0;
    localparam logic [7:0] SPECIAL_DOWN   = 8'd1;
    localparam logic [7:0] SPECIAL_LEFT   = 8'd2;
    localparam logic [7:0] SPECIAL_RIGHT  = 8'd3;
    localparam logic [7:0] SPECIAL_SHIFT_BIT = 8'd4;
    localparam logic [7:0] SPECIAL_CTRL_S = 8'd8;
    localparam logic [7:0] SPECIAL_CTRL_C = 8'd9;
    localparam logic [7:0] SPECIAL_CTRL_V = 8'd10;
    localparam logic [7:0] SPECIAL_CTRL_Y = 8'd11;
    localparam logic [7:0] SPECIAL_CTRL_Z = 8'd12;
    localparam logic [7:0] SPECIAL_LAST   = SPECIAL_CTRL_Z;

    localparam logic [7:0] PLAIN_MAP [LAYOUT_ENTRIES] = '{
        8'h00, 8'h5E, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36,
        8'h37, 8'h38, 8'h39, 8'h30, 8'h2D, 8'h3D, 8'h00,
        8'h00, 8'h71, 8'h77, 8'h65, 8'h72, 8'h74, 8'h7A, 8'h75,
        8'h69, 8'h6F, 8'h70, 8'h00, 8'h2B, 8'h0A,
        8'h00, 8'h61, 8'h73, 8'h64, 8'h66, 8'h67, 8'h68, 8'h6A,
        8'h6B, 8'h6C, 8'h00, 8'h00, 8'h5E,
        8'h00, 8'h3C, 8'h79, 8'h78, 8'h63, 8'h76, 8'h62, 8'h6E,
        8'h6D, 8'h2C, 8'h2E, 8'h2D, 8'h00,
        8'h00, 8'h00, 8'h20
    };

    localparam logic [7:0] UPPER_MAP [LAYOUT_ENTRIES] = '{
        8'h00, 8'h00, 8'h21, 8'h22, 8'h00, 8'h24, 8'h25, 8'h26,
        8'h2F, 8'h28, 8'h29, 8'h3D, 8'h3F, 8'h60, 8'h00,
        8'h00, 8'h51, 8'h57, 8'h45, 8'h52, 8'h54, 8'h5A, 8'h55,
        8'h49, 8'h4F, 8'h50, 8'h00, 8'h2A, 8'h0A,
        8'h00, 8'h41, 8'h53, 8'h44, 8'h46, 8'h47, 8'h48, 8'h4A,
        8'h4B, 8'h4C, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h3E, 8'h59, 8'h58, 8'h43, 8'h56, 8'h42, 8'h4E,
        8'h4D, 8'h3B, 8'h3A, 8'h5F, 8'h00,
        8'h00, 8'h00, 8'h20
    };

    typedef struct packed {
        logic       extended_pending;
        logic       shift_held;
        logic       ctrl_held;
        logic [7:0] last_printable;
    } key_state_t;

    typedef struct packed {
        logic       valid;
        logic       kind;
        logic [7:0] code;
        logic [7:0] last_char;
    } key_result_t;

    // Layout lookup; codes past the table read as zero
    function automatic logic [7:0] layout_char(input logic [7:0] sc, input logic upper);
        logic [7:0] ch;
        ch = 8'h00;
        if (sc < 8'(LAYOUT_ENTRIES)) begin
            ch = upper ? UPPER_MAP[sc[LAYOUT_AW-1:0]] : PLAIN_MAP[sc[LAYOUT_AW-1:0]];
        end
        return ch;
    endfunction

endpackage

`default_nettype wire

// ===== design/scancode_to_key_translator.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Scancode set 1 to key translator, German layout.
//
// Input stream: one raw scancode byte per transfer on s_tdata. Output stream:
// one key result per transfer, with m_tuser telling a plain character (0)
// from a special key index (1); m_tdata carries the key code and the last
// printable character seen from the layout tables.
// Prefix bytes, modifier make/break codes, other releases and unmapped keys
// produce no output transfer; prefix and modifier codes update the internal flags.
//
// Throughput: one scancode per cycle while the receiver does not stall; the
// decode is a single pass of flag logic and a 58-entry constant table lookup.
// Path: an input transfer passes the input register, then the result register,
// before m_tvalid rises; a pending result holds while the receiver stalls.
//
// Reset (aresetn low, synchronous): clear the prefix, shift and ctrl flags,
// the last printable character and both valid flags.
// Stall: while m_tready is low with a result pending, the result holds and
// the input register holds; s_tready drops once both stages are full.
module scancode_to_key_translator (
    input  wire logic        aclk,
    input  wire logic        aresetn,

    input  wire logic        s_tvalid,
    output      logic        s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] scancode

    output      logic        m_tvalid,
    input  wire logic        m_tready,
    output      logic [15:0] m_tdata,   // [7:0] key_code, [15:8] last_char
    output      logic        m_tuser    // [0] key_kind
);
    import sctk_pkg::*;

    // Input register stage
    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_code_reg;

    // Translator state
    key_state_t state_reg, state_next;

    // Result register stage
    logic        out_valid_reg, out_valid_next;
    logic        out_kind_reg;
    logic [15:0] out_data_reg;

    key_result_t dec_result;
    logic        out_advance;
    logic        in_take;

    // Result stage may load when empty or when its transfer completes
    assign out_advance = !out_valid_reg || m_tready;
    assign s_tready    = !in_valid_reg || out_advance;
    assign in_take     = s_tvalid && s_tready;

    sctk_decode u_decode (
        .scancode  (in_code_reg),
        .cur_state (state_reg),
        .nxt_state (state_next),
        .result    (dec_result)
    );

    always_comb begin
        in_valid_next = in_valid_reg;
        if (in_take) begin
            in_valid_next = 1'b1;
        end else if (out_advance) begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (out_advance) begin
            // Load a result only when the decoded item produces one
            out_valid_next = in_valid_reg && dec_result.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            // Commit flag updates as the item leaves the input register
            if (in_valid_reg && out_advance) begin
                state_reg <= state_next;
            end
        end
    end

    // Payload registers: no reset needed
    always_ff @(posedge aclk) begin
        if (in_take) begin
            in_code_reg <= s_tdata;
        end
        if (out_advance && in_valid_reg && dec_result.valid) begin
            out_kind_reg <= dec_result.kind;
            out_data_reg <= {dec_result.last_char, dec_result.code};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_kind_reg;

endmodule

`default_nettype wire

// ===== design/sctk_decode.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sctk_decode (
    input  wire logic [7:0]              scancode,
    input  wire sctk_pkg::key_state_t    cur_state,
    output sctk_pkg::key_state_t         nxt_state,
    output sctk_pkg::key_result_t        result
);
    import sctk_pkg::*;

    logic [7:0] shift_ofs;
    logic [7:0] layout_ch;

    assign shift_ofs = cur_state.shift_held ? SPECIAL_SHIFT_BIT : 8'd0;
    assign layout_ch = layout_char(scancode, cur_state.shift_held);

    always_comb begin
        nxt_state   = cur_state;
        result      = '0;
        result.kind = KIND_CHAR;

        priority if (scancode == SC_PREFIX) begin
            nxt_state.extended_pending = 1'b1;
        end else if (cur_state.extended_pending) begin
            // Only arrows survive the prefix
            nxt_state.extended_pending = 1'b0;
            result.kind = KIND_SPECIAL;
            unique case (scancode)
                SC_ARROW_UP: begin
                    result.valid = 1'b1;
                    result.code  = shift_ofs | SPECIAL_UP;
                end
                SC_ARROW_DOWN: begin
                    result.valid = 1'b1;
                    result.code  = shift_ofs | SPECIAL_DOWN;
                end
                SC_ARROW_LEFT: begin
                    result.valid = 1'b1;
                    result.code  = shift_ofs | SPECIAL_LEFT;
                end
                SC_ARROW_RIGHT: begin
                    result.valid = 1'b1;
                    result.code  = shift_ofs | SPECIAL_RIGHT;
                end
                default: result.valid = 1'b0;
            endcase
        end else if (scancode == SC_LSHIFT || scancode == SC_RSHIFT) begin
            nxt_state.shift_held = 1'b1;
        end else if (scancode == SC_LSHIFT_UP || scancode == SC_RSHIFT_UP) begin
            nxt_state.shift_held = 1'b0;
        end else if (scancode == SC_CTRL) begin
            nxt_state.ctrl_held = 1'b1;
        end else if (scancode == SC_CTRL_UP) begin
            nxt_state.ctrl_held = 1'b0;
        end else if (scancode[7]) begin
            // drop other releases
            result.valid = 1'b0;
        end else if (scancode == SC_ESC) begin
            result.valid = 1'b1;
            result.code  = CHAR_ESC;
        end else if (scancode == SC_BACKSPACE) begin
            result.valid = 1'b1;
            result.code  = CHAR_BACKSPACE;
        end else if (cur_state.ctrl_held) begin
            result.kind = KIND_SPECIAL;
            unique case (scancode)
                SC_KEY_S: begin
                    result.valid = 1'b1;
                    result.code  = SPECIAL_CTRL_S;
                end
                SC_KEY_C: begin
                    result.valid = 1'b1;
                    result.code  = SPECIAL_CTRL_C;
                end
                SC_KEY_V: begin
                    result.valid = 1'b1;
                    result.code  = SPECIAL_CTRL_V;
                end
                SC_KEY_Y: begin
                    result.valid = 1'b1;
                    result.code  = SPECIAL_CTRL_Y;
                end
                SC_KEY_Z: begin
                    result.valid = 1'b1;
                    result.code  = SPECIAL_CTRL_Z;
                end
                default: result.valid = 1'b0;
            endcase
        end else if (layout_ch != 8'h00) begin
            nxt_state.last_printable = layout_ch;
            result.valid = 1'b1;
            result.code  = layout_ch;
        end else begin
            result.valid = 1'b0;
        end

        result.last_char = nxt_state.last_printable;
    end

endmodule

`default_nettype wire

// ===== design/sctk_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sctk_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [15:0] m_tdata,
    input wire logic        m_tuser
);
    import sctk_pkg::*;

    // Reset empties the result stage
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // A pending result holds while stalled
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // Special key indexes stay inside the defined range
    a_special_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata[7:0] <= SPECIAL_LAST)
        else $error("special index out of range");

    // A table character is also the new last printable character
    a_char_tracks_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser && m_tdata[7:0] != CHAR_ESC && m_tdata[7:0] != CHAR_BACKSPACE
        |-> m_tdata[15:8] == m_tdata[7:0])
        else $error("last_char does not track emitted character");

    // With no result pending the input side never stalls
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid && s_tvalid |-> s_tready)
        else $error("input stalled with empty result stage");

endmodule

bind scancode_to_key_translator sctk_checker u_sctk_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire
